// ===== design/mnf_pkg.sv =====
// Shared types and constants for the Mitchell-Netravali filter weight block.
`timescale 1ns / 1ps

package mnf_pkg;

  // Field widths fixed by the interface
  localparam int OFFSET_W = 32;
  localparam int SCALE_W  = 24;
  localparam int PARAM_W  = 20;
  localparam int WEIGHT_W = 20;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Register reset values
  localparam logic [SCALE_W-1:0]        SCALE_RST = 24'd65536;
  localparam logic signed [PARAM_W-1:0] B_RST     = 20'sd21845;
  localparam logic signed [PARAM_W-1:0] C_RST     = 20'sd21845;

  // Output range and the final divide by three
  localparam int OUT_MAX  = 524287;
  localparam int OUT_MIN  = -524288;
  localparam int SAT_HI   = 3 * OUT_MAX + 2;
  localparam int SAT_LO   = 3 * OUT_MIN;
  localparam int U_BIAS   = -SAT_LO;
  localparam int U_W      = 22;
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 23;
  localparam logic [RECIP_W-1:0] RECIP = 23'd5592406;
  localparam int Q_BIAS   = -OUT_MIN;

  // Register map, by word index
  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_B     = 2'd1,
    REG_C     = 2'd2
  } reg_idx_e;

endpackage

// ===== design/mitchell_netravali_filter_weight.sv =====
// Top level: pipelined Mitchell-Netravali cubic filter weight evaluator.
`timescale 1ns / 1ps

//  channel   direction  protocol   payload
//  s_axis    in         stream     tdata[31:0] offset (Q15.16, signed)
//  m_axis    out        stream     tdata[19:0] weight (Q3.16, signed), [23:20] zero
//  apb       in         APB write  scale_two_over_radius, b_param, c_param
//
// Eight register stages; one offset is taken per cycle while the pipeline is not
// held by an output stall, and its weight is presented from the last stage register.
// The chain runs abs, scale multiply, square, cube, coefficient products, sum and
// the reciprocal divide by three.
// Each stage holds its own valid bit and takes new data whenever it is empty or
// the stage after it moves, so bubbles close up under an output stall.
// Reset clears all valid bits and restores the three registers.

module mitchell_netravali_filter_weight
  import mnf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] offset
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // [19:0] weight, [23:20] zero
);

  localparam int NST = 8;
  localparam int TW  = FRAC_BITS + 1;           // t below two
  localparam int T2W = FRAC_BITS + 2;           // t^2 below four
  localparam int T3W = FRAC_BITS + 3;           // t^3 below eight
  localparam int SQW = 2 * FRAC_BITS + 2;
  localparam int CBW = T2W + TW;
  localparam int PRW = OFFSET_W + SCALE_W;
  localparam int KW  = ((FRAC_BITS > 20) ? FRAC_BITS : 20) + 8;
  localparam int PW  = KW + FRAC_BITS + 4;
  localparam int AW  = PW + 2;
  localparam int ZW  = AW - FRAC_BITS - 1;
  localparam int QPW = U_W + RECIP_W;
  localparam logic signed [KW-1:0] ONE_K  = KW'(1) <<< FRAC_BITS;
  // half of the divisor six, in units of the constant term
  localparam logic signed [KW-1:0] HALF_K = KW'(3);

  // Configuration registers
  logic [SCALE_W-1:0]        scale_q;
  logic signed [PARAM_W-1:0] b_q, c_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write a register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      b_q     <= B_RST;
      c_q     <= C_RST;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        REG_B:     b_q     <= $signed(pwdata[PARAM_W-1:0]);
        REG_C:     c_q     <= $signed(pwdata[PARAM_W-1:0]);
        default:   ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SCALE: prdata = APB_DW'(scale_q);
      REG_B:     prdata = APB_DW'(b_q);
      REG_C:     prdata = APB_DW'(c_q);
      default:   prdata = '0;
    endcase
  end

  // Valid bits and per-stage ready chain
  logic [NST-1:0] vld_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = ~vld_q[NST-1] | m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NST-1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: magnitude of the offset
  logic [OFFSET_W-1:0] mag_d, mag_q;
  assign mag_d = s_axis_tdata[OFFSET_W-1] ? (~s_axis_tdata + OFFSET_W'(1)) : s_axis_tdata;

  // Stage 1: scaled magnitude
  logic [PRW-1:0] prod_d, prod_q;
  assign prod_d = PRW'(mag_q) * PRW'(scale_q);

  // Stage 2: t, support test, square and polynomial coefficients
  logic [TW-1:0]         t_d, t_q2;
  logic                  far_d, far_q2;
  logic [SQW-1:0]        sq_d, sq_q;
  logic signed [KW-1:0]  bx, cx;
  logic signed [KW-1:0]  k3_d, k2_d, k1_d, k0_d;
  logic signed [KW-1:0]  k3_q2, k2_q2, k1_q2, k0_q2;

  assign t_d   = prod_q[2*FRAC_BITS:FRAC_BITS];
  assign far_d = |prod_q[PRW-1:2*FRAC_BITS+1];
  assign sq_d  = SQW'(t_d) * SQW'(t_d);
  assign bx    = KW'(b_q);
  assign cx    = KW'(c_q);

  // Pick the inner or outer cubic; the rounding half is folded into k0
  always_comb begin
    if (!t_d[FRAC_BITS]) begin
      k3_d = (ONE_K <<< 3) + (ONE_K <<< 2) - ((bx <<< 3) + bx) - ((cx <<< 2) + (cx <<< 1));
      k2_d = (bx <<< 3) + (bx <<< 2) + (cx <<< 2) + (cx <<< 1)
             - ((ONE_K <<< 4) + (ONE_K <<< 1));
      k1_d = '0;
      k0_d = (ONE_K <<< 2) + (ONE_K <<< 1) - (bx <<< 1) + HALF_K;
    end else begin
      k3_d = -bx - ((cx <<< 2) + (cx <<< 1));
      k2_d = (bx <<< 2) + (bx <<< 1) + (cx <<< 5) - (cx <<< 1);
      k1_d = -((bx <<< 3) + (bx <<< 2)) - ((cx <<< 5) + (cx <<< 4));
      k0_d = (bx <<< 3) + (cx <<< 4) + (cx <<< 3) + HALF_K;
    end
  end

  // Stage 3: cube and the lower-order products
  logic [T2W-1:0]       t2;
  logic [CBW-1:0]       cube_d, cube_q;
  logic signed [PW-1:0] k2t2_d, k2t2_q, k1t_d, k1t_q;
  logic signed [KW-1:0] k3_q3, k0_q3;
  logic                 far_q3;

  assign t2     = sq_q[2*FRAC_BITS+1:FRAC_BITS];
  assign cube_d = CBW'(t2) * CBW'(t_q2);
  assign k2t2_d = PW'(k2_q2) * PW'($signed({1'b0, t2}));
  assign k1t_d  = PW'(k1_q2) * PW'($signed({1'b0, t_q2}));

  // Stage 4: cubic term and partial sum
  logic [T3W-1:0]       t3;
  logic signed [PW-1:0] k3t3_d, k3t3_q;
  logic signed [AW-1:0] rest_d, rest_q;
  logic                 far_q4;

  assign t3     = cube_q[2*FRAC_BITS+2:FRAC_BITS];
  assign k3t3_d = PW'(k3_q3) * PW'($signed({1'b0, t3}));
  assign rest_d = AW'(k2t2_q) + AW'(k1t_q) + (AW'(k0_q3) <<< FRAC_BITS);

  // Stage 5: full sum
  logic signed [AW-1:0] acc_d, acc_q;
  logic                 far_q5;

  assign acc_d = AW'(k3t3_q) + rest_q;

  // Stage 6: drop the fraction and the factor two of six, test range, bias
  logic signed [ZW-1:0] z, zb;
  logic [U_W-1:0]       u_d, u_q;
  logic                 hi_d, lo_d, hi_q, lo_q, far_q6;

  assign z    = $signed(acc_q[AW-1:FRAC_BITS+1]);
  assign hi_d = z > ZW'(SAT_HI);
  assign lo_d = z < ZW'(SAT_LO);
  assign zb   = z + ZW'(U_BIAS);
  assign u_d  = zb[U_W-1:0];

  // Stage 7: divide by three through the reciprocal, saturate
  logic [QPW-1:0]        qprod;
  logic [WEIGHT_W:0]     q, qb;
  logic [WEIGHT_W-1:0]   w_d, w_q;

  assign qprod = QPW'(u_q) * QPW'(RECIP);
  assign q     = qprod[RECIP_SH+WEIGHT_W:RECIP_SH];
  assign qb    = q - (WEIGHT_W+1)'(Q_BIAS);

  always_comb begin
    if (far_q6) begin
      w_d = '0;
    end else if (hi_q) begin
      w_d = WEIGHT_W'(OUT_MAX);
    end else if (lo_q) begin
      w_d = WEIGHT_W'(OUT_MIN);
    end else begin
      w_d = qb[WEIGHT_W-1:0];
    end
  end

  // Hold or advance the payload of each stage
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mag_q <= mag_d;
    end
    if (rdy[1]) begin
      prod_q <= prod_d;
    end
    if (rdy[2]) begin
      t_q2   <= t_d;
      far_q2 <= far_d;
      sq_q   <= sq_d;
      k3_q2  <= k3_d;
      k2_q2  <= k2_d;
      k1_q2  <= k1_d;
      k0_q2  <= k0_d;
    end
    if (rdy[3]) begin
      cube_q <= cube_d;
      k2t2_q <= k2t2_d;
      k1t_q  <= k1t_d;
      k3_q3  <= k3_q2;
      k0_q3  <= k0_q2;
      far_q3 <= far_q2;
    end
    if (rdy[4]) begin
      k3t3_q <= k3t3_d;
      rest_q <= rest_d;
      far_q4 <= far_q3;
    end
    if (rdy[5]) begin
      acc_q  <= acc_d;
      far_q5 <= far_q4;
    end
    if (rdy[6]) begin
      u_q    <= u_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      far_q6 <= far_q5;
    end
    if (rdy[7]) begin
      w_q <= w_d;
    end
  end

  assign m_axis_tdata = {4'b0000, w_q};

endmodule
